/* sv/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg: key matrix debouncer shared definitions
// Constants, defaults and the event batch passed from the key lanes to the
// event serializer.
// ----------------------------------------------------------------------------
package kmd_pkg;

  localparam int LEVEL_BITS     = 4;
  localparam int ROW_W          = $clog2(LEVEL_BITS);
  localparam int COL_W          = 4;
  localparam int TIME_W         = 32;
  localparam int DEBOUNCE_W     = 16;
  localparam int ROWS_DEFAULT   = 4;
  localparam int COLS_DEFAULT   = 9;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] fire;
    logic [LEVEL_BITS-1:0] level;
    logic [COL_W-1:0]      column;
  } kmd_batch_t;

endpackage

/* sv/kmd_lane.sv */
// ----------------------------------------------------------------------------
// kmd_lane: debounce state for one row of the matrix
// Keeps raw level, stable level and last change time for every column of one
// row and flags a stable level change for the addressed key.
// ----------------------------------------------------------------------------
module kmd_lane #(
  parameter int COLS = kmd_pkg::COLS_DEFAULT,
  parameter int CW   = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [CW-1:0]                   col_idx,
  input  logic                            raw,
  input  logic [kmd_pkg::TIME_W-1:0]      now_ms,
  input  logic [kmd_pkg::DEBOUNCE_W-1:0]  debounce_ms,
  output logic                            fire
);
  import kmd_pkg::*;

  logic              raw_seen    [COLS];
  logic              stable_keys [COLS];
  logic [TIME_W-1:0] change_time [COLS];

  logic              changed;
  logic [TIME_W-1:0] ct_eff;
  logic [TIME_W-1:0] elapsed;

  always_comb begin
    changed = raw != raw_seen[col_idx];
    ct_eff  = changed ? now_ms : change_time[col_idx];
    elapsed = now_ms - ct_eff;
    fire    = (raw != stable_keys[col_idx]) &&
              (elapsed >= TIME_W'(debounce_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLS; c++) begin
        raw_seen[c]    <= 1'b0;
        stable_keys[c] <= 1'b0;
        change_time[c] <= '0;
      end
    end else if (en) begin
      raw_seen[col_idx] <= raw;
      if (changed) begin
        change_time[col_idx] <= now_ms;
      end
      if (fire) begin
        stable_keys[col_idx] <= raw;
      end
    end
  end

endmodule

/* sv/kmd_merge.sv */
// ----------------------------------------------------------------------------
// kmd_merge: event serializer
// Holds the events one scan produced and hands them out one transaction at a
// time, lowest row first, through a registered output stage.
// ----------------------------------------------------------------------------
module kmd_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  kmd_pkg::kmd_batch_t         batch,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kmd_pkg::ROW_W-1:0]   key_row,
  output logic [kmd_pkg::COL_W-1:0]   key_column,
  output logic                        pressed,
  output logic                        last_event
);
  import kmd_pkg::*;

  logic [LEVEL_BITS-1:0] mask;
  logic [LEVEL_BITS-1:0] levels;
  logic [COL_W-1:0]      column;

  logic [ROW_W-1:0]      sel;
  logic [LEVEL_BITS-1:0] rest;
  logic                  move;

  always_comb begin
    sel = '0;
    for (int i = LEVEL_BITS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = ROW_W'(i);
      end
    end
    rest = mask;
    rest[sel] = 1'b0;
    move = (|mask) && (!out_valid || !out_stall);
    free = !(|mask) || (move && !(|rest));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= batch.fire;
    end else if (move) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      levels <= batch.level;
      column <= batch.column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      key_row    <= sel;
      key_column <= column;
      pressed    <= levels[sel];
      last_event <= !(|rest);
    end
  end

endmodule

/* sv/key_matrix_debouncer.sv */
// ----------------------------------------------------------------------------
// key_matrix_debouncer: key matrix scan debouncer
// Debounces the keys of one scanned column per transaction and reports each
// stable press or release as a separate output transaction.
// ----------------------------------------------------------------------------
// First event path: accept loads the event mask, then the output register.
// Flow: a scan causes at most 4 events, sent one at a time by the serializer;
//   it takes a new scan as the last event leaves; all lanes update together.
// Reset: synchronous; all keys released, change times zero, debounce_ms = 20.
// ----------------------------------------------------------------------------
module key_matrix_debouncer #(
  parameter int ROWS = kmd_pkg::ROWS_DEFAULT,
  parameter int COLS = kmd_pkg::COLS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kmd_pkg::DEBOUNCE_W-1:0]  debounce_ms,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kmd_pkg::COL_W-1:0]       column,
  input  logic [kmd_pkg::LEVEL_BITS-1:0]  row_levels,
  input  logic [kmd_pkg::TIME_W-1:0]      now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kmd_pkg::ROW_W-1:0]       key_row,
  output logic [kmd_pkg::COL_W-1:0]       key_column,
  output logic                            pressed,
  output logic                            last_event
);
  import kmd_pkg::*;

  localparam int LANES = (ROWS < LEVEL_BITS) ? ROWS : LEVEL_BITS;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int XW    = (CW > COL_W) ? CW : COL_W;

  logic [DEBOUNCE_W-1:0] debounce;
  logic                  accept;
  logic                  in_range;
  logic                  free;
  logic [XW-1:0]         col_ext;
  logic [CW-1:0]         col_idx;
  kmd_batch_t            batch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce <= debounce_ms;
    end
  end

  assign in_stall = !free;
  assign accept   = in_valid && !in_stall;
  assign col_ext  = XW'(column);
  assign col_idx  = col_ext[CW-1:0];
  assign in_range = 32'(column) < 32'(COLS);

  assign batch.level  = row_levels;
  assign batch.column = column;

  for (genvar r = 0; r < LEVEL_BITS; r++) begin : g_lane
    if (r < LANES) begin : g_on
      logic hit;
      kmd_lane #(
        .COLS (COLS),
        .CW   (CW)
      ) u_lane (
        .clk         (clk),
        .rst         (rst),
        .en          (accept && in_range),
        .col_idx     (col_idx),
        .raw         (row_levels[r]),
        .now_ms      (now_ms),
        .debounce_ms (debounce),
        .fire        (hit)
      );
      assign batch.fire[r] = hit && in_range;
    end else begin : g_off
      assign batch.fire[r] = 1'b0;
    end
  end

  kmd_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .batch      (batch),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_row    (key_row),
    .key_column (key_column),
    .pressed    (pressed),
    .last_event (last_event)
  );

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_event) |=> out_valid)
    else $error("event burst broke before its last event");

  a_burst_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_event) |=>
      (key_column == $past(key_column)) && (key_row > $past(key_row)))
    else $error("events of one scan out of order or mixed columns");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(key_column) < 32'(COLS)))
    else $error("event reported for a column outside the matrix");

endmodule

/* test/key_matrix_debouncer_tb.sv */
// ----------------------------------------------------------------------------
// key_matrix_debouncer_tb: self-checking bench for the key matrix debouncer
// Feeds column scans through a stall-driven driver and predicts the press
// and release events for each accepted scan. A monitor compares every output
// transaction, field by field, against the oldest predicted event. Covers
// several debounce settings, including zero and the maximum, timestamp wrap,
// out-of-range columns, random input idle gaps and random output stalls.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_tb;

  import kmd_pkg::*;

  localparam int ROWS        = 4;
  localparam int COLS        = 9;
  localparam int IDLE_PCT    = 36;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [COL_W-1:0]      col;
    logic [LEVEL_BITS-1:0] levels;
    logic [TIME_W-1:0]     now;
  } scan_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             pressed;
    logic             last;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [DEBOUNCE_W-1:0] debounce_ms = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COL_W-1:0]      column = '0;
  logic [LEVEL_BITS-1:0] row_levels = '0;
  logic [TIME_W-1:0]     now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_W-1:0]      key_row;
  logic [COL_W-1:0]      key_column;
  logic                  pressed;
  logic                  last_event;

  key_matrix_debouncer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .debounce_ms(debounce_ms),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .column     (column),
    .row_levels (row_levels),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_row    (key_row),
    .key_column (key_column),
    .pressed    (pressed),
    .last_event (last_event)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [DEBOUNCE_W-1:0] hold_ms = DEBOUNCE_RESET;
  logic                  raw_level [ROWS*COLS];
  logic                  stable_level [ROWS*COLS];
  logic [TIME_W-1:0]     stamp [ROWS*COLS];

  scan_t      pending_scans [$];
  key_event_t expected_events [$];
  scan_t      shown;
  int         n_queued = 0;
  int         n_accepted = 0;
  int         mismatches = 0;
  int         cycles = 0;
  bit         calm = 1'b0;

  // Stimulus generator state
  logic [TIME_W-1:0]     clock_ms = '0;
  logic [LEVEL_BITS-1:0] held [COLS];
  int                    scan_col = 0;

  initial begin
    for (int i = 0; i < ROWS*COLS; i++) begin
      raw_level[i] = 1'b0;
      stable_level[i] = 1'b0;
      stamp[i] = '0;
    end
    for (int c = 0; c < COLS; c++) held[c] = '0;
  end

  function automatic void debounce_scan(input scan_t s);
    key_event_t batch [$];
    key_event_t ev;
    int idx;
    logic raw;
    logic [TIME_W-1:0] elapsed;
    if (s.col >= COLS) return;
    for (int r = 0; r < ROWS && r < LEVEL_BITS; r++) begin
      idx = r * COLS + int'(s.col);
      raw = s.levels[r];
      if (raw != raw_level[idx]) begin
        raw_level[idx] = raw;
        stamp[idx] = s.now;
      end
      elapsed = s.now - stamp[idx];
      if (raw != stable_level[idx] && elapsed >= {16'b0, hold_ms}) begin
        stable_level[idx] = raw;
        ev.row = ROW_W'(r);
        ev.col = s.col;
        ev.pressed = raw;
        ev.last = 1'b0;
        batch.push_back(ev);
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_events.push_back(batch[i]);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: hold while stalled, advance on accept
  always @(posedge clk) begin : drive
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        debounce_scan(shown);
        n_accepted++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_scans.size() > 0 &&
                   (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        shown = pending_scans.pop_front();
        in_valid <= 1'b1;
        column <= shown.col;
        row_levels <= shown.levels;
        now_ms <= shown.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin : watch
    key_event_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("unexpected transaction: row %0d column %0d pressed %0d",
                 key_row, key_column, pressed);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("key_row", want.row, key_row);
          check_field("key_column", want.col, key_column);
          check_field("pressed", want.pressed, pressed);
          check_field("last_event", want.last, last_event);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_scan(input int col, input int levels, input logic [TIME_W-1:0] now);
    scan_t s;
    s.col = COL_W'(col);
    s.levels = LEVEL_BITS'(levels);
    s.now = now;
    pending_scans.push_back(s);
    n_queued++;
  endtask

  task automatic settle();
    while (n_accepted != n_queued || expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_hold(input int value);
    cfg_valid <= 1'b1;
    debounce_ms <= DEBOUNCE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    hold_ms = DEBOUNCE_W'(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-order column scans with held keys, bounce and steady time;
  // the rest is out-of-range columns, wild timestamps and time going back.
  task automatic queue_scans(input int count, input int step_max);
    int kind;
    int col;
    logic [LEVEL_BITS-1:0] levels;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        col = scan_col;
        scan_col = (scan_col + 1) % COLS;
        clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
        if ($urandom_range(0, 3) == 0)
          held[col] = held[col] ^ LEVEL_BITS'(1 << $urandom_range(0, LEVEL_BITS-1));
        levels = held[col];
        if ($urandom_range(0, 7) == 0)
          levels = levels ^ LEVEL_BITS'(1 << $urandom_range(0, LEVEL_BITS-1));
        queue_scan(col, levels, clock_ms);
      end else if (kind < 88) begin
        queue_scan($urandom_range(COLS, 15), $urandom_range(0, 15), $urandom);
      end else if (kind < 94) begin
        clock_ms = $urandom;
        queue_scan($urandom_range(0, COLS-1), $urandom_range(0, 15), clock_ms);
      end else begin
        col = $urandom_range(0, COLS-1);
        queue_scan(col, held[col], clock_ms - TIME_W'($urandom_range(1, 4*step_max)));
      end
    end
  endtask

  initial begin : stimulus
    int holds [5];
    holds = '{65535, 3, 0, 150, 20};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset debounce time
    queue_scan(0, 4'hF, 32'd0);
    queue_scan(0, 4'hF, 32'd20);
    queue_scan(0, 4'h0, 32'd25);
    queue_scan(0, 4'h0, 32'd44);
    queue_scan(0, 4'h0, 32'd45);
    queue_scan(15, 4'hF, 32'd100);
    queue_scan(9, 4'hF, 32'd200);
    queue_scan(8, 4'hA, 32'hFFFF_FFF0);
    queue_scan(8, 4'hA, 32'd4);
    queue_scan(8, 4'hA, 32'd3);
    queue_scan(1, 4'h1, 32'd1000);
    queue_scan(1, 4'h1, 32'd500);
    queue_scan(2, 4'h1, 32'd2000);
    queue_scan(2, 4'h0, 32'd2005);
    queue_scan(2, 4'h1, 32'd2010);
    queue_scan(2, 4'h1, 32'd2029);
    queue_scan(2, 4'h1, 32'd2030);
    queue_scan(3, 4'h2, 32'hFFFF_FFFF);
    queue_scan(3, 4'h2, 32'h0000_0013);
    settle();

    // Zero debounce
    write_hold(0);
    queue_scan(4, 4'h5, 32'd7);
    queue_scan(4, 4'hA, 32'd7);
    queue_scan(4, 4'hA, 32'd7);
    settle();

    clock_ms = $urandom;
    foreach (holds[p]) begin
      write_hold(holds[p]);
      calm = (p == 1);
      queue_scans(92, holds[p] / 6 + 1);
      settle();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
